// File: rtl/aarm_pkg.sv
// Shared types, constants and helpers of the axis-angle rotation matrix unit.
// No dependencies; every rtl file refers to it by scoped names.
package aarm_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 14;

  // pipeline depths of the fixed sections
  localparam int ANGLE_PRE_STAGES = 4;
  localparam int SUMSQ_STAGES     = 1;
  localparam int SQRT_STAGES      = 32;
  localparam int RECIP_STAGES     = 45;
  localparam int SCALE_STAGES     = 2;
  localparam int NORM_LAT         = SUMSQ_STAGES + SQRT_STAGES + RECIP_STAGES + SCALE_STAGES;
  localparam int MATRIX_STAGES    = 3;

  // angle in 1/64 degree
  localparam logic signed [16:0] DEG_HALF_TURN = 17'sd11520;
  localparam logic signed [16:0] DEG_QUARTER   = 17'sd5760;
  localparam logic signed [16:0] DEG_FULL      = 17'sd23040;

  // pi in Q32 = 11520 * RAD_WHOLE + RAD_REM
  localparam logic [20:0] RAD_WHOLE   = 21'd1171270;
  localparam logic [12:0] RAD_REM     = 13'd7305;
  // floor(y / 45) = (y * DIV45_RECIP) >> DIV45_SHIFT for y < 2^18
  localparam logic [18:0] DIV45_RECIP = 19'd372828;
  localparam int          DIV45_SHIFT = 24;

  localparam longint GAIN_Q30 = 64'sd652032874;

  localparam int ATAN_ENTRIES = 24;
  localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
    64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
    64'sd1024,      64'sd512,       64'sd256,       64'sd128
  };

  localparam logic signed [15:0] ONE_Q14  = 16'sd16384;
  localparam logic [1:0]         COL_LAST = 2'd3;

  // round half up, then arithmetic shift right
  function automatic longint rnd_shr(input longint v, input int sh);
    longint r;
    if (sh == 0) begin
      r = v;
    end else begin
      r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    end
    return r;
  endfunction

  typedef struct packed {
    logic signed [15:0] angle_deg;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } item_t;

  typedef struct packed {
    logic [1:0]         column_index;
    logic signed [15:0] row0;
    logic signed [15:0] row1;
    logic signed [15:0] row2;
    logic signed [15:0] row3;
    logic               last;
    logic               axis_zero;
  } column_t;

  // upper 3x3 block, e[col][row], Q2.14
  typedef struct packed {
    logic                  zero;
    logic [2:0][2:0][15:0] e;
  } mat_t;

endpackage

// File: rtl/aarm_angle.sv
// Angle path: wrap to a quarter turn, degrees to radians, pipelined CORDIC.
// Depends on aarm_pkg.
module aarm_angle #(
  parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [15:0]        angle_deg,
  output logic signed [FRAC_BITS+2:0] cos_q,
  output logic signed [FRAC_BITS+2:0] sin_q
);

  localparam int ZW = FRAC_BITS + 3;
  localparam logic signed [ZW-1:0] GAIN =
    ZW'(aarm_pkg::rnd_shr(aarm_pkg::GAIN_Q30, 30 - FRAC_BITS));

  logic signed [16:0] d0, d1, d2;
  logic               flip_c, neg_c;
  logic [12:0]        mag_c;

  logic [12:0] mag1;
  logic        neg1, flip1;
  logic [33:0] pa2;
  logic [25:0] pb2;
  logic        neg2, flip2;
  logic [33:0] pa3;
  logic [11:0] fq3;
  logic        neg3, flip3;
  logic [33:0] qm;
  logic signed [63:0] qs;
  logic signed [ZW-1:0] z4;
  logic                 flip4;

  logic signed [ZW-1:0] cx [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
  logic                 fl [CORDIC_STAGES+1];

  always_comb begin
    d0 = 17'(angle_deg);
    if (d0 >= aarm_pkg::DEG_HALF_TURN) begin
      d1 = d0 - aarm_pkg::DEG_FULL;
    end else if (d0 < -aarm_pkg::DEG_HALF_TURN) begin
      d1 = d0 + aarm_pkg::DEG_FULL;
    end else begin
      d1 = d0;
    end
    flip_c = 1'b0;
    d2     = d1;
    if (d1 > aarm_pkg::DEG_QUARTER) begin
      d2     = d1 - aarm_pkg::DEG_HALF_TURN;
      flip_c = 1'b1;
    end else if (d1 < -aarm_pkg::DEG_QUARTER) begin
      d2     = d1 + aarm_pkg::DEG_HALF_TURN;
      flip_c = 1'b1;
    end
    neg_c = d2[16];
    mag_c = neg_c ? 13'(-d2) : 13'(d2);
  end

  assign qm = pa3 + 34'(fq3);
  assign qs = neg3 ? -$signed({30'b0, qm}) : $signed({30'b0, qm});

  always_ff @(posedge clk) begin
    if (en) begin
      mag1  <= mag_c;
      neg1  <= neg_c;
      flip1 <= flip_c;
      pa2   <= 34'(mag1) * 34'(aarm_pkg::RAD_WHOLE);
      pb2   <= 26'(mag1) * 26'(aarm_pkg::RAD_REM) + 26'(aarm_pkg::DEG_QUARTER);
      neg2  <= neg1;
      flip2 <= flip1;
      pa3   <= pa2;
      fq3   <= 12'((37'(pb2[25:8]) * 37'(aarm_pkg::DIV45_RECIP)) >> aarm_pkg::DIV45_SHIFT);
      neg3  <= neg2;
      flip3 <= flip2;
      z4    <= ZW'(aarm_pkg::rnd_shr(qs, 32 - FRAC_BITS));
      flip4 <= flip3;
    end
  end

  assign cx[0] = GAIN;
  assign cy[0] = '0;
  assign cz[0] = z4;
  assign fl[0] = flip4;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    localparam logic signed [ZW-1:0] T =
      ZW'(aarm_pkg::rnd_shr(aarm_pkg::ATAN_Q30[i], 30 - FRAC_BITS));
    logic signed [ZW-1:0] dx, dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][ZW-1]) begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - T;
        end else begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + T;
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  assign cos_q = fl[CORDIC_STAGES] ? -cx[CORDIC_STAGES] : cx[CORDIC_STAGES];
  assign sin_q = fl[CORDIC_STAGES] ? -cy[CORDIC_STAGES] : cy[CORDIC_STAGES];

endmodule

// File: rtl/aarm_norm.sv
// Axis path: sum of squares, pipelined square root, pipelined reciprocal,
// scaling of the axis to unit length. Depends on aarm_pkg.
module aarm_norm #(
  parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [15:0]          axis_x,
  input  logic signed [15:0]          axis_y,
  input  logic signed [15:0]          axis_z,
  output logic signed [FRAC_BITS+1:0] u_x,
  output logic signed [FRAC_BITS+1:0] u_y,
  output logic signed [FRAC_BITS+1:0] u_z,
  output logic                        axis_zero
);

  localparam int SQ = aarm_pkg::SQRT_STAGES;
  localparam int DV = aarm_pkg::RECIP_STAGES;
  localparam int UW = FRAC_BITS + 2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               zero;
  } axis_carry_t;

  logic signed [31:0] wx, wy, wz;
  logic [31:0]        sq_x, sq_y, sq_z, l2_c;

  logic [63:0]  sn [SQ+1];
  logic [63:0]  sr [SQ+1];
  axis_carry_t  sc [SQ+1];

  logic [60:0]  num_c;
  logic [31:0]  len_c;
  logic [31:0]  dr [DV+1];
  logic [44:0]  dq [DV+1];
  logic [44:0]  dn [DV+1];
  logic [31:0]  dd [DV+1];
  axis_carry_t  dc [DV+1];

  logic signed [39:0] pl_x, pl_y, pl_z;
  logic signed [38:0] ph_x, ph_y, ph_z;
  logic               zero_s;
  logic signed [63:0] full_x, full_y, full_z;

  assign wx   = 32'(axis_x);
  assign wy   = 32'(axis_y);
  assign wz   = 32'(axis_z);
  assign sq_x = wx * wx;
  assign sq_y = wy * wy;
  assign sq_z = wz * wz;
  assign l2_c = sq_x + sq_y + sq_z;

  always_ff @(posedge clk) begin
    if (en) begin
      sn[0]      <= {l2_c, 32'b0};
      sr[0]      <= '0;
      sc[0].x    <= axis_x;
      sc[0].y    <= axis_y;
      sc[0].z    <= axis_z;
      sc[0].zero <= (l2_c == 32'd0);
    end
  end

  // digit-by-digit square root, one result bit per stage
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [63:0] B = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = sr[j] + B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sn[j] >= trial) begin
          sn[j+1] <= sn[j] - trial;
          sr[j+1] <= (sr[j] >> 1) + B;
        end else begin
          sn[j+1] <= sn[j];
          sr[j+1] <= sr[j] >> 1;
        end
        sc[j+1] <= sc[j];
      end
    end
  end

  assign len_c = sr[SQ][31:0];
  assign num_c = (61'd1 << 60) + 61'(len_c >> 1);
  assign dr[0] = 32'(num_c[60:45]);
  assign dn[0] = num_c[44:0];
  assign dd[0] = len_c;
  assign dq[0] = '0;
  assign dc[0] = sc[SQ];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DV; k++) begin : g_div
    logic [32:0] t;
    logic        ge;
    assign t  = {dr[k], dn[k][44]};
    assign ge = (t >= {1'b0, dd[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        dr[k+1] <= ge ? 32'(t - {1'b0, dd[k]}) : t[31:0];
        dq[k+1] <= {dq[k][43:0], ge};
        dn[k+1] <= dn[k] << 1;
        dd[k+1] <= dd[k];
        dc[k+1] <= dc[k];
      end
    end
  end

  assign full_x = (64'(ph_x) <<< 23) + 64'(pl_x);
  assign full_y = (64'(ph_y) <<< 23) + 64'(pl_y);
  assign full_z = (64'(ph_z) <<< 23) + 64'(pl_z);

  always_ff @(posedge clk) begin
    if (en) begin
      pl_x      <= 40'(dc[DV].x) * $signed({17'b0, dq[DV][22:0]});
      pl_y      <= 40'(dc[DV].y) * $signed({17'b0, dq[DV][22:0]});
      pl_z      <= 40'(dc[DV].z) * $signed({17'b0, dq[DV][22:0]});
      ph_x      <= 39'(dc[DV].x) * $signed({17'b0, dq[DV][44:23]});
      ph_y      <= 39'(dc[DV].y) * $signed({17'b0, dq[DV][44:23]});
      ph_z      <= 39'(dc[DV].z) * $signed({17'b0, dq[DV][44:23]});
      zero_s    <= dc[DV].zero;
      u_x       <= UW'(aarm_pkg::rnd_shr(full_x, 44 - FRAC_BITS));
      u_y       <= UW'(aarm_pkg::rnd_shr(full_y, 44 - FRAC_BITS));
      u_z       <= UW'(aarm_pkg::rnd_shr(full_z, 44 - FRAC_BITS));
      axis_zero <= zero_s;
    end
  end

endmodule

// File: rtl/aarm_matrix.sv
// Matrix terms c*I + (1-c)*u*u^T + s*[u]x, rounded and saturated to Q2.14.
// Depends on aarm_pkg.
module aarm_matrix #(
  parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC_BITS+1:0] u_x,
  input  logic signed [FRAC_BITS+1:0] u_y,
  input  logic signed [FRAC_BITS+1:0] u_z,
  input  logic signed [FRAC_BITS+2:0] cos_q,
  input  logic signed [FRAC_BITS+2:0] sin_q,
  input  logic                        axis_zero,
  output aarm_pkg::mat_t              mat
);

  localparam int PW = 2 * FRAC_BITS + 8;
  localparam int SW = FRAC_BITS + 5;
  localparam int XW = SW + 16;
  localparam int SH_DN = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
  localparam int SH_UP = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
  localparam logic signed [PW-1:0] HALF   = PW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [XW-1:0] HALF14 = XW'((64'sd1 <<< SH_DN) >>> 1);
  localparam logic signed [SW-1:0] ONE    = SW'(64'sd1 <<< FRAC_BITS);

  function automatic logic signed [SW-1:0] mq(input logic signed [PW-1:0] a,
                                              input logic signed [PW-1:0] b);
    logic signed [PW-1:0] r;
    r = ((a * b) + HALF) >>> FRAC_BITS;
    return SW'(r);
  endfunction

  function automatic logic [15:0] q14(input logic signed [SW-1:0] v);
    logic signed [XW-1:0] r;
    logic [15:0]          o;
    r = ((XW'(v) + HALF14) >>> SH_DN) <<< SH_UP;
    if (r > 32767) begin
      o = 16'h7fff;
    end else if (r < -32768) begin
      o = 16'h8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  logic signed [SW-1:0] xx, yy, zz, xy, yz, zx, xs, ys, zs, c1, nc1;
  logic                 z1;
  logic signed [SW-1:0] xxn, yyn, zzn, xyn, yzn, zxn, xs2, ys2, zs2, c2;
  logic                 z2;

  always_ff @(posedge clk) begin
    if (en) begin
      xx  <= mq(PW'(u_x), PW'(u_x));
      yy  <= mq(PW'(u_y), PW'(u_y));
      zz  <= mq(PW'(u_z), PW'(u_z));
      xy  <= mq(PW'(u_x), PW'(u_y));
      yz  <= mq(PW'(u_y), PW'(u_z));
      zx  <= mq(PW'(u_z), PW'(u_x));
      xs  <= mq(PW'(u_x), PW'(sin_q));
      ys  <= mq(PW'(u_y), PW'(sin_q));
      zs  <= mq(PW'(u_z), PW'(sin_q));
      c1  <= SW'(cos_q);
      nc1 <= ONE - SW'(cos_q);
      z1  <= axis_zero;

      xxn <= mq(PW'(xx), PW'(nc1));
      yyn <= mq(PW'(yy), PW'(nc1));
      zzn <= mq(PW'(zz), PW'(nc1));
      xyn <= mq(PW'(xy), PW'(nc1));
      yzn <= mq(PW'(yz), PW'(nc1));
      zxn <= mq(PW'(zx), PW'(nc1));
      xs2 <= xs;
      ys2 <= ys;
      zs2 <= zs;
      c2  <= c1;
      z2  <= z1;

      mat.e[0][0] <= q14(xxn + c2);
      mat.e[0][1] <= q14(xyn + zs2);
      mat.e[0][2] <= q14(zxn - ys2);
      mat.e[1][0] <= q14(xyn - zs2);
      mat.e[1][1] <= q14(yyn + c2);
      mat.e[1][2] <= q14(yzn + xs2);
      mat.e[2][0] <= q14(zxn + ys2);
      mat.e[2][1] <= q14(yzn - xs2);
      mat.e[2][2] <= q14(zzn + c2);
      mat.zero    <= z2;
    end
  end

endmodule

// File: rtl/aarm_ser.sv
// Output stage: holds one finished matrix and sends it as four column words.
// Depends on aarm_pkg.
module aarm_ser (
  input  logic                clk,
  input  logic                rst,
  input  logic                tail_valid,
  input  aarm_pkg::mat_t      mat_in,
  output logic                load,
  output logic                column_valid,
  input  logic                column_stall,
  output aarm_pkg::column_t   column
);

  logic           busy;
  logic [1:0]     col;
  aarm_pkg::mat_t mat;
  logic           take;

  assign take = busy && !column_stall;
  assign load = !busy || (take && col == aarm_pkg::COL_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      col  <= '0;
    end else if (load) begin
      busy <= tail_valid;
      col  <= '0;
    end else if (take) begin
      col  <= col + 2'd1;
    end
    if (load) begin
      mat <= mat_in;
    end
  end

  always_comb begin
    column_valid        = busy;
    column.column_index = col;
    column.last         = (col == aarm_pkg::COL_LAST);
    column.axis_zero    = mat.zero;
    column.row0         = '0;
    column.row1         = '0;
    column.row2         = '0;
    column.row3         = '0;
    if (mat.zero) begin
      case (col)
        2'd0:    column.row0 = aarm_pkg::ONE_Q14;
        2'd1:    column.row1 = aarm_pkg::ONE_Q14;
        2'd2:    column.row2 = aarm_pkg::ONE_Q14;
        default: column.row3 = aarm_pkg::ONE_Q14;
      endcase
    end else if (col == aarm_pkg::COL_LAST) begin
      column.row3 = aarm_pkg::ONE_Q14;
    end else begin
      column.row0 = mat.e[col][0];
      column.row1 = mat.e[col][1];
      column.row2 = mat.e[col][2];
    end
  end

endmodule

// File: rtl/axis_angle_rotation_matrix_unit.sv
// Axis-angle to 4x4 rotation matrix, top level.
// Depends on aarm_pkg, aarm_angle, aarm_norm, aarm_matrix, aarm_ser.
//
// Each input word (angle in Q10.6 degrees, axis in Q2.14) yields four column
// words of the column-major matrix, column 0 first, last set on column 3; a
// zero-length axis yields the identity with axis_zero set. The datapath is a
// stall-together pipeline of 83 stages (sum of squares, 32-stage square root,
// 45-stage reciprocal, axis scaling, three product stages); the angle path and
// its CORDIC run alongside and are delay-matched. Input words enter once a
// cycle until the pipeline fills; after that the input rate is set by the
// output port sending four column words per matrix, and column stalls hold it.
module axis_angle_rotation_matrix_unit #(
  parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  aarm_pkg::item_t   item,
  output logic              column_valid,
  input  logic              column_stall,
  output aarm_pkg::column_t column
);

  localparam int CW        = FRAC_BITS + 3;
  localparam int UW        = FRAC_BITS + 2;
  localparam int ANGLE_LAT = aarm_pkg::ANGLE_PRE_STAGES + CORDIC_STAGES;
  localparam int ALIGN     = aarm_pkg::NORM_LAT - ANGLE_LAT;
  localparam int PIPE_LAT  = aarm_pkg::NORM_LAT + aarm_pkg::MATRIX_STAGES;

  logic                 en, load, tail_valid;
  logic [PIPE_LAT-1:0]  vld;
  logic signed [CW-1:0] cos_a, sin_a, cos_d, sin_d;
  logic [2*CW-1:0]      cs_dly [ALIGN];
  logic signed [UW-1:0] u_x, u_y, u_z;
  logic                 axis_zero;
  aarm_pkg::mat_t       mat;

  assign tail_valid = vld[PIPE_LAT-1];
  assign en         = !tail_valid || load;
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], item_valid};
    end
  end

  aarm_angle #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_angle (
    .clk      (clk),
    .en       (en),
    .angle_deg(item.angle_deg),
    .cos_q    (cos_a),
    .sin_q    (sin_a)
  );

  // line the angle results up with the axis path
  always_ff @(posedge clk) begin
    if (en) begin
      cs_dly[0] <= {cos_a, sin_a};
      for (int k = 1; k < ALIGN; k++) begin
        cs_dly[k] <= cs_dly[k-1];
      end
    end
  end

  assign cos_d = cs_dly[ALIGN-1][2*CW-1:CW];
  assign sin_d = cs_dly[ALIGN-1][CW-1:0];

  aarm_norm #(
    .FRAC_BITS(FRAC_BITS)
  ) u_norm (
    .clk      (clk),
    .en       (en),
    .axis_x   (item.axis_x),
    .axis_y   (item.axis_y),
    .axis_z   (item.axis_z),
    .u_x      (u_x),
    .u_y      (u_y),
    .u_z      (u_z),
    .axis_zero(axis_zero)
  );

  aarm_matrix #(
    .FRAC_BITS(FRAC_BITS)
  ) u_matrix (
    .clk      (clk),
    .en       (en),
    .u_x      (u_x),
    .u_y      (u_y),
    .u_z      (u_z),
    .cos_q    (cos_d),
    .sin_q    (sin_d),
    .axis_zero(axis_zero),
    .mat      (mat)
  );

  aarm_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .tail_valid  (tail_valid),
    .mat_in      (mat),
    .load        (load),
    .column_valid(column_valid),
    .column_stall(column_stall),
    .column      (column)
  );

endmodule

// File: rtl/aarm_chk.sv
// Port-level checks of the rotation matrix unit, bound to the top level.
// Depends on aarm_pkg and axis_angle_rotation_matrix_unit.
module aarm_chk (
  input logic              clk,
  input logic              rst,
  input logic              column_valid,
  input logic              column_stall,
  input aarm_pkg::column_t column
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    column_valid && column_stall |=> column_valid && $stable(column))
    else $error("column word changed while stalled");

  a_next_col: assert property (@(posedge clk) disable iff (rst)
    column_valid && !column_stall && column.column_index != aarm_pkg::COL_LAST |=>
      column_valid && column.column_index == $past(column.column_index) + 2'd1)
    else $error("column words out of order");

  a_last: assert property (@(posedge clk) disable iff (rst)
    column_valid |-> column.last == (column.column_index == aarm_pkg::COL_LAST))
    else $error("last flag on wrong column");

  a_zero_held: assert property (@(posedge clk) disable iff (rst)
    column_valid && !column_stall && column.column_index != aarm_pkg::COL_LAST |=>
      column.axis_zero == $past(column.axis_zero))
    else $error("axis_zero changed within a matrix");

  a_col3: assert property (@(posedge clk) disable iff (rst)
    column_valid && column.column_index == aarm_pkg::COL_LAST |->
      column.row0 == 16'sd0 && column.row1 == 16'sd0 && column.row2 == 16'sd0 &&
      column.row3 == aarm_pkg::ONE_Q14)
    else $error("last column is not 0,0,0,1");

endmodule

bind axis_angle_rotation_matrix_unit aarm_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .column_valid(column_valid),
  .column_stall(column_stall),
  .column      (column)
);
